// File: src/pni_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pni_pkg
// shared types, constants and helpers of the polynomial newton inverse block
// ----------------------------------------------------------------------------
package pni_pkg;

    localparam int DEF_MAX_DEGREE = 5;
    localparam int DEF_MAX_STEPS  = 100;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int DATA_W  = 32;
    localparam int DEG_W   = 3;
    localparam int TOL_W   = 16;
    localparam int STEPS_W = 7;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DEGREE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEFF0    = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEFF5    = 3'd6;
    localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_DER  = 2'd2;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,      // load target, cur = 1.0, prev = 0, n = 0
        OP_DERC,      // build derivative coefficient for index in idx
        OP_CHECK,     // form |cur - prev|
        OP_HP_LOAD,   // acc = coeff[d]
        OP_HD_LOAD,   // acc = dc[d-1]
        OP_MUL,       // prod = acc * cur
        OP_HP_ADD,    // acc = sat(fmul + coeff[i])
        OP_HD_ADD,    // acc = sat(fmul + dc[i])
        OP_SAVE_DER,  // der = acc
        OP_RES,       // res = sat(y - acc), start divider
        OP_DIV,       // one quotient bit
        OP_UPDATE     // prev = cur, cur = sat(cur + q), n++
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [DEG_W-1:0] idx;
    } pni_cmd_t;

    typedef struct packed {
        logic within_tol;
        logic der_zero;
        logic div_done;
    } pni_stat_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DERC, S_CHECK, S_DECIDE,
        S_HD_LOAD, S_HD_MUL, S_HD_ADD, S_HD_SAVE,
        S_HP_LOAD, S_HP_MUL, S_HP_ADD, S_RES, S_DIV, S_UPDATE, S_OUT
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+33:0] v);
        logic signed [DATA_W+33:0] hi;
        logic signed [DATA_W+33:0] lo;
        begin
            hi = (DATA_W+34)'(signed'(33'sh0_7FFF_FFFF));
            lo = -hi - (DATA_W+34)'(1);
            if (v > hi)
                sat32 = {1'b0, {(DATA_W-1){1'b1}}};
            else if (v < lo)
                sat32 = {1'b1, {(DATA_W-1){1'b0}}};
            else
                sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

// File: src/pni_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pni_datapath
// registers, multiplier and serial divider of the newton iteration
// ----------------------------------------------------------------------------
module pni_datapath
    import pni_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pni_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] target,
    input  logic signed [DATA_W-1:0] coeff [6],
    input  logic [TOL_W-1:0]         tol,
    output pni_stat_t                stat,
    output logic signed [DATA_W-1:0] root,
    output logic [STEPS_W-1:0]       steps
);

    localparam int DIV_W = DATA_W + FRAC_BITS + 1;   // magnitude of dividend
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int PW    = 2 * DATA_W;

    logic signed [DATA_W-1:0] y_reg, cur_reg, prev_reg, acc_reg, der_reg;
    logic signed [DATA_W-1:0] dc_reg [5];
    logic signed [PW-1:0]     prod_reg;
    logic [33:0]              diff_reg;
    logic [STEPS_W-1:0]       n_reg;

    // divider state: restoring, one bit per beat
    logic [DIV_W-1:0]         dvd_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        dvs_reg;
    logic                     qneg_reg;
    logic [CNT_W-1:0]         dcnt_reg;

    logic signed [PW-1:0]     pshift;
    logic signed [DATA_W-1:0] fm;
    logic signed [DATA_W+33:0] ext_sum;
    logic signed [DATA_W-1:0] resv;
    logic signed [DATA_W+1:0] dtmp;
    logic [DATA_W:0]          rem_sh, rem_sub;
    logic [DIV_W-1:0]         qmag;
    logic signed [DIV_W:0]    qs;
    logic signed [DATA_W-1:0] qsat;
    logic signed [DATA_W+33:0] upd;

    // floor shift of product then saturate
    assign pshift = prod_reg >>> FRAC_BITS;
    assign fm     = sat32((DATA_W+34)'(pshift));

    always_comb begin
        ext_sum = '0;
        case (cmd.op)
            OP_HP_ADD: ext_sum = (DATA_W+34)'(fm) + (DATA_W+34)'(coeff[cmd.idx]);
            OP_HD_ADD: ext_sum = (DATA_W+34)'(fm) + (DATA_W+34)'(dc_reg[cmd.idx]);
            default:   ext_sum = '0;
        endcase
    end

    assign resv = sat32((DATA_W+34)'(y_reg) - (DATA_W+34)'(acc_reg));
    assign dtmp = (DATA_W+2)'(cur_reg) - (DATA_W+2)'(prev_reg);

    // divider step
    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign qmag    = dvd_reg;
    assign qs      = qneg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    always_comb begin
        if (qs > (DIV_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}})))
            qsat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (qs < -(DIV_W+1)'(signed'({1'b0, {(DATA_W-1){1'b1}}})) - (DIV_W+1)'(1))
            qsat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            qsat = qs[DATA_W-1:0];
    end
    assign upd = (DATA_W+34)'(cur_reg) + (DATA_W+34)'(qsat);

    // register updates per command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= '0;
            dcnt_reg <= '0;
        end else begin
            case (cmd.op)
                OP_INIT: begin
                    y_reg    <= target;
                    cur_reg  <= DATA_W'(1) <<< FRAC_BITS;
                    prev_reg <= '0;
                    n_reg    <= '0;
                end
                OP_DERC: dc_reg[cmd.idx] <= sat32((DATA_W+34)'(coeff[cmd.idx + 3'd1])
                                                  * (DATA_W+34)'(cmd.idx + 3'd1));
                OP_CHECK: diff_reg <= dtmp[DATA_W+1] ? 34'(-dtmp) : 34'(dtmp);
                OP_HP_LOAD: acc_reg <= coeff[cmd.idx];
                OP_HD_LOAD: acc_reg <= dc_reg[cmd.idx];
                OP_MUL: prod_reg <= PW'(acc_reg) * PW'(cur_reg);
                OP_HP_ADD, OP_HD_ADD: acc_reg <= sat32(ext_sum);
                OP_SAVE_DER: der_reg <= acc_reg;
                OP_RES: begin
                    dvd_reg  <= DIV_W'(resv[DATA_W-1] ? -(DATA_W+1)'(resv)
                                                      : (DATA_W+1)'(resv))
                                << FRAC_BITS;
                    dvs_reg  <= der_reg[DATA_W-1] ? -der_reg : der_reg;
                    qneg_reg <= resv[DATA_W-1] ^ der_reg[DATA_W-1];
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                end
                OP_DIV: begin
                    if (rem_sub[DATA_W]) begin
                        rem_reg <= rem_sh[DATA_W-1:0];
                        dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                    end else begin
                        rem_reg <= rem_sub[DATA_W-1:0];
                        dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b1};
                    end
                    dcnt_reg <= dcnt_reg + CNT_W'(1);
                end
                OP_UPDATE: begin
                    prev_reg <= cur_reg;
                    cur_reg  <= sat32(upd);
                    n_reg    <= n_reg + STEPS_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign stat.within_tol = diff_reg <= 34'(tol);
    assign stat.der_zero   = der_reg == '0;
    assign stat.div_done   = dcnt_reg == CNT_W'(DIV_W);
    assign root  = cur_reg;
    assign steps = n_reg;

endmodule

// File: src/pni_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pni_ctrl
// sequencer of newton steps, horner passes and divider beats
// ----------------------------------------------------------------------------
module pni_ctrl
    import pni_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic [DEG_W-1:0]   degree,
    input  pni_stat_t          stat,
    output pni_cmd_t           cmd,
    output logic [STAT_W-1:0]  status
);

    localparam int NW = $clog2(MAX_STEPS + 1);

    state_t              state_reg, state_next;
    logic [DEG_W-1:0]    d_reg, d_next, i_reg, i_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [STAT_W-1:0]   st_reg, st_next;
    logic [DEG_W-1:0]    deff;

    assign deff = (degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;

    // next state
    always_comb begin
        state_next = state_reg;
        d_next = d_reg;
        i_next = i_reg;
        n_next = n_reg;
        st_next = st_reg;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                d_next = deff;
                i_next = '0;
                n_next = '0;
                state_next = (deff == '0) ? S_CHECK : S_DERC;
            end
            S_DERC: begin
                i_next = i_reg + DEG_W'(1);
                if (i_reg + DEG_W'(1) == d_reg) state_next = S_CHECK;
            end
            S_CHECK: state_next = S_DECIDE;
            S_DECIDE: begin
                if (stat.within_tol) begin
                    st_next = ST_CONVERGED; state_next = S_OUT;
                end else if (n_reg >= NW'(MAX_STEPS)) begin
                    st_next = ST_LIMIT; state_next = S_OUT;
                end else if (d_reg == '0) begin
                    st_next = ST_ZERO_DER; state_next = S_OUT;
                end else begin
                    i_next = d_reg - DEG_W'(1);
                    state_next = S_HD_LOAD;
                end
            end
            S_HD_LOAD: state_next = (i_reg == '0) ? S_HD_SAVE : S_HD_MUL;
            S_HD_MUL: begin
                i_next = i_reg - DEG_W'(1);
                state_next = S_HD_ADD;
            end
            S_HD_ADD: state_next = (i_reg == '0) ? S_HD_SAVE : S_HD_MUL;
            S_HD_SAVE: state_next = S_HP_LOAD;
            S_HP_LOAD: begin
                if (stat.der_zero) begin
                    st_next = ST_ZERO_DER; state_next = S_OUT;
                end else begin
                    i_next = d_reg;
                    state_next = S_HP_MUL;
                end
            end
            S_HP_MUL: begin
                i_next = i_reg - DEG_W'(1);
                state_next = S_HP_ADD;
            end
            S_HP_ADD: state_next = (i_reg == '0) ? S_RES : S_HP_MUL;
            S_RES: state_next = S_DIV;
            S_DIV: if (stat.div_done) state_next = S_UPDATE;
            S_UPDATE: begin
                n_next = n_reg + NW'(1);
                state_next = S_CHECK;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (!aresetn) state_next = S_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg <= '0;
        end else begin
            state_reg <= state_next;
            n_reg <= n_next;
        end
        d_reg <= d_next;
        i_reg <= i_next;
        st_reg <= st_next;
    end

    // command outputs
    always_comb begin
        cmd.op = OP_NONE;
        cmd.idx = i_reg;
        case (state_reg)
            S_IDLE:    if (s_valid) cmd.op = OP_INIT;
            S_DERC:    cmd.op = OP_DERC;
            S_CHECK:   cmd.op = OP_CHECK;
            S_HD_LOAD: cmd.op = OP_HD_LOAD;
            S_HD_MUL:  cmd.op = OP_MUL;
            S_HD_ADD:  cmd.op = OP_HD_ADD;
            S_HD_SAVE: cmd.op = OP_SAVE_DER;
            S_HP_LOAD: begin
                cmd.op = OP_HP_LOAD;
                cmd.idx = d_reg;
            end
            S_HP_MUL:  cmd.op = OP_MUL;
            S_HP_ADD:  cmd.op = OP_HP_ADD;
            S_RES:     cmd.op = OP_RES;
            S_DIV:     if (!stat.div_done) cmd.op = OP_DIV;
            S_UPDATE:  cmd.op = OP_UPDATE;
            default:   cmd.op = OP_NONE;
        endcase
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;
    assign status  = st_reg;

endmodule

// File: src/polynomial_newton_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_newton_inverse
// finds x with P(x) = target by fixed-point newton iteration
// ----------------------------------------------------------------------------
// usage:
//   s_valid/s_ready carry one target beat (signed Q16.16); m_valid/m_ready
//   carry one result beat: root, steps and status.
//   configuration: cfg_we, cfg_index, cfg_data write degree (0), coeff_0..5
//   (1..6) and tolerance (7); the user must write them only while the block
//   is idle; the block itself does not enforce this.
// sequence:
//   one item at a time. setup builds the derivative coefficients, then each
//   newton step runs horner passes and bookkeeping on the single multiplier
//   followed by the restoring divider; up to MAX_STEPS steps per item.
// reset:
//   aresetn (synchronous, low) returns the sequencer to idle and sets the
//   registers to degree 1, P(x) = x, tolerance 0.
// stall:
//   the result is held on m_ports until m_ready; no new target is taken
//   until the result beat has gone.
// ----------------------------------------------------------------------------
module polynomial_newton_inverse
    import pni_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int MAX_STEPS  = DEF_MAX_STEPS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [DATA_W-1:0]         cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [DATA_W-1:0]  s_target,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DATA_W-1:0]  m_root,
    output logic [STEPS_W-1:0]        m_steps,
    output logic [STAT_W-1:0]         m_status
);

    logic [DEG_W-1:0]         degree_reg;
    logic signed [DATA_W-1:0] coeff_reg [6];
    logic [TOL_W-1:0]         tol_reg;
    pni_cmd_t                 cmd;
    pni_stat_t                stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= DEG_W'(1);
            tol_reg    <= '0;
            for (int k = 0; k < 6; k++)
                coeff_reg[k] <= (k == 1) ? (DATA_W'(1) <<< FRAC_BITS) : '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_DEGREE)
                degree_reg <= cfg_data[DEG_W-1:0];
            else if (cfg_index == REG_TOLERANCE)
                tol_reg <= cfg_data[TOL_W-1:0];
            else if (cfg_index >= REG_COEFF0 && cfg_index <= REG_COEFF5)
                coeff_reg[cfg_index - REG_COEFF0] <= cfg_data;
        end
    end

    pni_ctrl #(
        .MAX_DEGREE (MAX_DEGREE),
        .MAX_STEPS  (MAX_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .degree  (degree_reg),
        .stat    (stat),
        .cmd     (cmd),
        .status  (m_status)
    );

    pni_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .target  (s_target),
        .coeff   (coeff_reg),
        .tol     (tol_reg),
        .stat    (stat),
        .root    (m_root),
        .steps   (m_steps)
    );

endmodule

// File: src/pni_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pni_checker
// port-level checks of the polynomial newton inverse block
// ----------------------------------------------------------------------------
module pni_checker
    import pni_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_root,
    input logic [STAT_W-1:0] m_status
);

    // result beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root))
        else $error("result changed while stalled");

    // never ready for input while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready with result pending");

    // status code is meaningful
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_CONVERGED || m_status == ST_LIMIT
                     || m_status == ST_ZERO_DER))
        else $error("bad status");

    // accepted target does not yield a result in the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");

endmodule

bind polynomial_newton_inverse pni_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_root   (m_root),
    .m_status (m_status)
);
